/* rtl/i2c_register_access_master_top_assert.svh */
// ----------------------------------------------------------------------------
// I2C register access master assertion macros
// Shared concurrent assertion forms, clocked by clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef I2C_REGISTER_ACCESS_MASTER_TOP_ASSERT_SVH
`define I2C_REGISTER_ACCESS_MASTER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define I2CRA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define I2CRA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/i2cra_pkg.sv */
// ----------------------------------------------------------------------------
// I2C register access master package
// Beat payload types, configuration register indexes and reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package i2cra_pkg;

	localparam int DEV_ADDR_W    = 7;
	localparam int TIMEOUT_W     = 10;
	localparam int CFG_INDEX_W   = 2;
	localparam int CFG_DATA_W    = 10;

	localparam logic [DEV_ADDR_W-1:0] DEV_ADDR_RESET    = 7'd20;
	localparam logic [TIMEOUT_W-1:0]  ACK_TIMEOUT_RESET = 10'd250;

	localparam logic [CFG_INDEX_W-1:0] CFG_DEVICE_ADDRESS = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_ACK_TIMEOUT    = 2'd1;

	typedef struct packed {
		logic        start_req;
		logic        opcode;
		logic [15:0] reg_addr;
		logic [5:0]  byte_count;
		logic [7:0]  write_data;
		logic        sda_in;
	} cmd_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic [7:0] read_data;
		logic       read_valid;
		logic       data_taken;
		logic       busy_res;
		logic       done_res;
		logic       status;
	} rsp_t;

	typedef struct packed {
		logic [CFG_INDEX_W-1:0] index;
		logic [CFG_DATA_W-1:0]  value;
	} cfg_t;

endpackage

`default_nettype wire

/* rtl/i2cra_chan_if.sv */
// ----------------------------------------------------------------------------
// I2C register access master channel interface
// Valid/ready channel carrying one payload beat of a chosen type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface i2cra_chan_if #(
	parameter type T = logic
) ();

	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

/* rtl/i2c_register_access_master_top.sv */
// ----------------------------------------------------------------------------
// I2C register access master top level
// Open-drain I2C master for targets with 16-bit register addresses, one
// command beat per bus half-period tick and one response beat for each.
// ----------------------------------------------------------------------------
// Each command beat is one half-period tick of the bus and yields exactly one
// response beat with the SCL and SDA drive for that tick. A beat is accepted
// every clock cycle as long as the response register is empty or is drained
// in the same cycle; the state update is one pass of logic from the state
// registers into the response register, so each response beat is registered.
`timescale 1ns / 1ps
`default_nettype none

module i2c_register_access_master_top #(
	parameter int MAX_BYTES = 32
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	i2cra_chan_if.sink   cmd,
	i2cra_chan_if.source rsp,
	i2cra_chan_if.sink   cfg
);

	logic [i2cra_pkg::DEV_ADDR_W-1:0] dev_addr_q;
	logic [i2cra_pkg::TIMEOUT_W-1:0]  timeout_q;
	logic                             rsp_valid_q;
	i2cra_pkg::rsp_t                  rsp_data_q;
	i2cra_pkg::rsp_t                  step_rsp;
	logic                             step;

	assign cmd.ready = !rsp_valid_q || rsp.ready;
	assign step      = cmd.valid && cmd.ready;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;
	assign cfg.ready = 1'b1;

	i2cra_engine #(
		.MAX_BYTES(MAX_BYTES)
	) u_engine (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (step),
		.cmd            (cmd.data),
		.device_address (dev_addr_q),
		.ack_timeout    (timeout_q),
		.rsp            (step_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= i2cra_pkg::DEV_ADDR_RESET;
			timeout_q  <= i2cra_pkg::ACK_TIMEOUT_RESET;
		end else if (cfg.valid) begin
			case (cfg.data.index)
				i2cra_pkg::CFG_DEVICE_ADDRESS: begin
					dev_addr_q <= cfg.data.value[i2cra_pkg::DEV_ADDR_W-1:0];
				end
				i2cra_pkg::CFG_ACK_TIMEOUT: begin
					timeout_q <= cfg.data.value[i2cra_pkg::TIMEOUT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (step) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			rsp_data_q <= step_rsp;
		end
	end

endmodule

`default_nettype wire

/* rtl/i2cra_engine.sv */
// ----------------------------------------------------------------------------
// I2C register access master bus engine
// Holds the transaction state and computes the line drive and status of
// one half-period tick from the registered state and the accepted beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "i2c_register_access_master_top_assert.svh"

module i2cra_engine #(
	parameter int MAX_BYTES = 32
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             step,
	input  wire i2cra_pkg::cmd_t                  cmd,
	input  wire logic [i2cra_pkg::DEV_ADDR_W-1:0] device_address,
	input  wire logic [i2cra_pkg::TIMEOUT_W-1:0]  ack_timeout,
	output i2cra_pkg::rsp_t                       rsp
);

	typedef enum logic [4:0] {
		PH_IDLE     = 5'd0,
		PH_START    = 5'd1,
		PH_RESTART  = 5'd2,
		PH_TX_DEVW  = 5'd3,
		PH_TX_ADRH  = 5'd4,
		PH_TX_ADRL  = 5'd5,
		PH_TX_DATA  = 5'd6,
		PH_TX_DEVR  = 5'd7,
		PH_ACK_DEVW = 5'd8,
		PH_ACK_ADRH = 5'd9,
		PH_ACK_ADRL = 5'd10,
		PH_ACK_DATA = 5'd11,
		PH_ACK_DEVR = 5'd12,
		PH_RX       = 5'd13,
		PH_RACK     = 5'd14,
		PH_STOP_OK  = 5'd15,
		PH_STOP_ERR = 5'd16
	} phase_t;

	phase_t      phase_q, n_phase;
	logic [1:0]  sub_q, n_sub;
	logic [2:0]  bit_q, n_bit;
	logic [5:0]  byte_q, n_byte;
	logic [7:0]  shift_q, n_shift;
	logic [9:0]  wait_q, n_wait;
	logic [15:0] addr_q, n_addr;
	logic [5:0]  len_q, n_len;
	logic        op_q, n_op;
	logic        scl_q, sda_q;

	logic        scl, sda;
	logic [7:0]  cur_shift;
	logic [5:0]  byte_inc;
	logic        last_byte;
	logic        ack_expired;
	logic [5:0]  sat_len;

	always_comb begin
		n_phase     = phase_q;
		n_sub       = sub_q;
		n_bit       = bit_q;
		n_byte      = byte_q;
		n_shift     = shift_q;
		n_wait      = wait_q;
		n_addr      = addr_q;
		n_len       = len_q;
		n_op        = op_q;
		scl         = scl_q;
		sda         = sda_q;
		cur_shift   = shift_q;
		byte_inc    = byte_q + 6'd1;
		last_byte   = ({1'b0, byte_q} + 7'd1) >= {1'b0, len_q};
		ack_expired = ({1'b0, wait_q} + 11'd1) >= {1'b0, ack_timeout};
		sat_len     = ({3'b000, cmd.byte_count} > 9'(MAX_BYTES)) ? 6'(MAX_BYTES)
			: cmd.byte_count;
		rsp         = '0;
		rsp.busy_res = 1'b1;

		case (phase_q)
			PH_IDLE: begin
				scl = 1'b1;
				sda = 1'b1;
				if (cmd.start_req) begin
					n_op    = cmd.opcode;
					n_addr  = cmd.reg_addr;
					n_len   = sat_len;
					n_byte  = '0;
					n_wait  = '0;
					n_phase = PH_START;
					n_sub   = 2'd1;
				end else begin
					rsp.busy_res = 1'b0;
				end
			end
			PH_START, PH_RESTART: begin
				case (sub_q)
					2'd0: begin
						scl   = 1'b1;
						sda   = 1'b1;
						n_sub = 2'd1;
					end
					2'd1: begin
						scl   = 1'b1;
						sda   = 1'b0;
						n_sub = 2'd2;
					end
					default: begin
						scl     = 1'b0;
						sda     = 1'b0;
						n_phase = (phase_q == PH_START) ? PH_TX_DEVW : PH_TX_DEVR;
						n_shift = {device_address, (phase_q == PH_RESTART)};
						n_bit   = 3'd7;
						n_sub   = 2'd0;
					end
				endcase
			end
			PH_TX_DEVW, PH_TX_ADRH, PH_TX_ADRL, PH_TX_DATA, PH_TX_DEVR: begin
				if (sub_q == 2'd0 && phase_q == PH_TX_DATA && bit_q == 3'd7) begin
					cur_shift      = cmd.write_data;
					rsp.data_taken = 1'b1;
				end
				n_shift = cur_shift;
				sda     = cur_shift[bit_q];
				case (sub_q)
					2'd0: begin
						scl   = 1'b0;
						n_sub = 2'd1;
					end
					2'd1: begin
						scl   = 1'b1;
						n_sub = 2'd2;
					end
					default: begin
						scl   = 1'b0;
						n_sub = 2'd0;
						if (bit_q == 3'd0) begin
							case (phase_q)
								PH_TX_DEVW: n_phase = PH_ACK_DEVW;
								PH_TX_ADRH: n_phase = PH_ACK_ADRH;
								PH_TX_ADRL: n_phase = PH_ACK_ADRL;
								PH_TX_DATA: n_phase = PH_ACK_DATA;
								default:    n_phase = PH_ACK_DEVR;
							endcase
						end else begin
							n_bit = bit_q - 3'd1;
						end
					end
				endcase
			end
			PH_ACK_DEVW, PH_ACK_ADRH, PH_ACK_ADRL, PH_ACK_DATA, PH_ACK_DEVR: begin
				case (sub_q)
					2'd0: begin
						scl   = 1'b0;
						sda   = 1'b1;
						n_sub = 2'd1;
					end
					2'd1: begin
						scl    = 1'b1;
						sda    = 1'b1;
						n_wait = '0;
						n_sub  = 2'd2;
					end
					default: begin
						if (!cmd.sda_in) begin
							scl = 1'b0;
							sda = 1'b1;
							case (phase_q)
								PH_ACK_DEVW: begin
									n_phase = PH_TX_ADRH;
									n_shift = addr_q[15:8];
									n_bit   = 3'd7;
									n_sub   = 2'd0;
								end
								PH_ACK_ADRH: begin
									n_phase = PH_TX_ADRL;
									n_shift = addr_q[7:0];
									n_bit   = 3'd7;
									n_sub   = 2'd0;
								end
								PH_ACK_ADRL: begin
									n_sub = 2'd0;
									if (!op_q) begin
										n_phase = PH_RESTART;
									end else if (len_q != 6'd0) begin
										n_byte  = '0;
										n_phase = PH_TX_DATA;
										n_shift = '0;
										n_bit   = 3'd7;
									end else begin
										n_phase = PH_STOP_OK;
									end
								end
								PH_ACK_DATA: begin
									n_byte = byte_inc;
									n_sub  = 2'd0;
									if (byte_inc < len_q) begin
										n_phase = PH_TX_DATA;
										n_shift = '0;
										n_bit   = 3'd7;
									end else begin
										n_phase = PH_STOP_OK;
									end
								end
								default: begin
									n_byte  = '0;
									n_sub   = 2'd0;
									n_phase = (len_q != 6'd0) ? PH_RX : PH_STOP_OK;
								end
							endcase
						end else if (ack_expired) begin
							scl     = 1'b1;
							sda     = 1'b0;
							n_phase = PH_STOP_ERR;
							n_sub   = 2'd1;
						end else begin
							n_wait = wait_q + 10'd1;
							scl    = 1'b1;
							sda    = 1'b1;
						end
					end
				endcase
			end
			PH_RX: begin
				sda = 1'b1;
				case (sub_q)
					2'd0: begin
						scl     = 1'b0;
						n_shift = '0;
						n_bit   = 3'd7;
						n_sub   = 2'd1;
					end
					2'd1: begin
						scl   = 1'b1;
						n_sub = 2'd2;
					end
					default: begin
						scl     = 1'b0;
						n_shift = {shift_q[6:0], cmd.sda_in};
						if (bit_q == 3'd0) begin
							rsp.read_valid = 1'b1;
							rsp.read_data  = n_shift;
							n_phase        = PH_RACK;
							n_sub          = 2'd0;
						end else begin
							n_bit = bit_q - 3'd1;
							n_sub = 2'd1;
						end
					end
				endcase
			end
			PH_RACK: begin
				sda = last_byte;
				case (sub_q)
					2'd0: begin
						scl   = 1'b0;
						n_sub = 2'd1;
					end
					2'd1: begin
						scl   = 1'b1;
						n_sub = 2'd2;
					end
					default: begin
						scl     = 1'b0;
						n_byte  = byte_inc;
						n_sub   = 2'd0;
						n_phase = (byte_inc < len_q) ? PH_RX : PH_STOP_OK;
					end
				endcase
			end
			PH_STOP_OK, PH_STOP_ERR: begin
				case (sub_q)
					2'd0: begin
						sda   = 1'b0;
						n_sub = 2'd1;
					end
					2'd1: begin
						scl   = 1'b1;
						sda   = 1'b0;
						n_sub = 2'd2;
					end
					default: begin
						scl          = 1'b1;
						sda          = 1'b1;
						rsp.done_res = 1'b1;
						rsp.status   = (phase_q == PH_STOP_ERR);
						n_phase      = PH_IDLE;
						n_sub        = 2'd0;
						n_bit        = 3'd7;
					end
				endcase
			end
			default: begin
				n_phase      = PH_IDLE;
				n_sub        = 2'd0;
				scl          = 1'b1;
				sda          = 1'b1;
				rsp.busy_res = 1'b0;
			end
		endcase

		rsp.scl_out = scl;
		rsp.sda_out = sda;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			sub_q   <= '0;
			bit_q   <= 3'd7;
			byte_q  <= '0;
			shift_q <= '0;
			wait_q  <= '0;
			addr_q  <= '0;
			len_q   <= '0;
			op_q    <= 1'b0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
		end else if (step) begin
			phase_q <= n_phase;
			sub_q   <= n_sub;
			bit_q   <= n_bit;
			byte_q  <= n_byte;
			shift_q <= n_shift;
			wait_q  <= n_wait;
			addr_q  <= n_addr;
			len_q   <= n_len;
			op_q    <= n_op;
			scl_q   <= scl;
			sda_q   <= sda;
		end
	end

	`I2CRA_ASSERT_NEXT(a_idle_holds, step && phase_q == PH_IDLE && !cmd.start_req, phase_q == PH_IDLE, "engine left idle without a request")
	`I2CRA_ASSERT_NEXT(a_done_to_idle, step && rsp.done_res, phase_q == PH_IDLE, "engine not idle after done")
	`I2CRA_ASSERT_NEXT(a_taken_latch, step && rsp.data_taken, shift_q == $past(cmd.write_data), "write byte not latched when taken")
	`I2CRA_ASSERT_NOW(a_done_busy, step && rsp.done_res, rsp.busy_res && scl && sda, "done reported without a released bus")

endmodule

`default_nettype wire
